// File: design/lfo_tremolo_autopan_unit_assert.svh
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef LFO_TREMOLO_AUTOPAN_UNIT_ASSERT_SVH
`define LFO_TREMOLO_AUTOPAN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ltau_pkg.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan package
// Shared constants, register indexes and table generator functions.
// ----------------------------------------------------------------------------
package ltau_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int GAIN_DEPTH_DEF  = 256;

  // Shared serial arithmetic widths.
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int DIV_QB = 13;
  localparam int DIV_RW = 23;

  localparam int GAIN_SPAN = 3072;
  localparam int UNITY_Q12 = 4096;
  localparam int VAR_MAX   = 4096;
  localparam int VR_MAX    = 120;
  localparam int PR_MAX    = 4096;
  localparam int GDB_DEN   = 5242880;
  localparam int IDX_DEN   = 6144;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_VAR    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_VRANGE = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PRANGE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STEP   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MODE   = 3'd4;

  localparam longint ONE_Q30     = longint'(1) <<< 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint LOG2_10_Q30 = 64'sd3566893132;
  localparam longint LN2_Q30     = 64'sd744261118;

  // Nested odd Taylor series of the sine up to the eleventh power.
  function automatic longint sin_q30(longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 30;
    t = ONE_Q30;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 110;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 72;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 6;
    return (x * t) >>> 30;
  endfunction

  // Exponential series to the thirteenth term.
  function automatic longint exp_q30(longint y);
    longint sum;
    longint term;
    sum = ONE_Q30;
    term = ONE_Q30;
    term = ((term * y) >>> 30) / 1;
    sum = sum + term;
    term = ((term * y) >>> 30) / 2;
    sum = sum + term;
    term = ((term * y) >>> 30) / 3;
    sum = sum + term;
    term = ((term * y) >>> 30) / 4;
    sum = sum + term;
    term = ((term * y) >>> 30) / 5;
    sum = sum + term;
    term = ((term * y) >>> 30) / 6;
    sum = sum + term;
    term = ((term * y) >>> 30) / 7;
    sum = sum + term;
    term = ((term * y) >>> 30) / 8;
    sum = sum + term;
    term = ((term * y) >>> 30) / 9;
    sum = sum + term;
    term = ((term * y) >>> 30) / 10;
    sum = sum + term;
    term = ((term * y) >>> 30) / 11;
    sum = sum + term;
    term = ((term * y) >>> 30) / 12;
    sum = sum + term;
    term = ((term * y) >>> 30) / 13;
    sum = sum + term;
    return sum;
  endfunction

  // One Q1.15 sine entry of a table with 2^b entries, built by quarter symmetry.
  function automatic longint sine_entry(int k, int b);
    longint q;
    longint quad;
    longint j;
    longint x;
    longint s;
    q = longint'(1) <<< (b - 2);
    quad = (longint'(k) >>> (b - 2)) & 3;
    case (quad)
      0: j = k;
      1: j = 2 * q - k;
      2: j = k - 2 * q;
      default: j = 4 * q - k;
    endcase
    x = (j * HALF_PI_Q30 + (q >>> 1)) >>> (b - 2);
    s = (sin_q30(x) + (longint'(1) <<< 14)) >>> 15;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -s : s;
  endfunction

  // Q2.14 gain from a log2 exponent given in Q30.
  function automatic longint gain_from_z(longint z);
    longint u;
    longint ip;
    longint frac;
    longint r;
    longint sh;
    longint g;
    u = z + 2 * ONE_Q30;
    ip = (u >>> 30) - 2;
    frac = u & (ONE_Q30 - 1);
    r = exp_q30((frac * LN2_Q30) >>> 30);
    sh = 16 - ip;
    if (sh < 1) sh = 1;
    if (sh > 40) sh = 40;
    g = (r + (longint'(1) <<< (sh - 1))) >>> sh;
    if (g > 65535) g = 65535;
    return g;
  endfunction

endpackage

// File: design/ltau_mul.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ltau_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ltau_pkg::MUL_AW-1:0] a,
  input  logic [ltau_pkg::MUL_BW-1:0] b,
  output logic                       done,
  output logic [ltau_pkg::MUL_AW-1:0] result
);
  import ltau_pkg::*;

  logic              busy;
  logic [MUL_AW-1:0] acc;
  logic [MUL_AW-1:0] a_sh;
  logic [MUL_BW-1:0] b_sh;

  // The run ends as soon as no multiplier bits remain.
  assign done   = busy && (b_sh == '0);
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (busy && !done) begin
      if (b_sh[0]) acc <= acc + a_sh;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// File: design/ltau_div.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltau_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ltau_pkg::MUL_AW-1:0] num,
  input  logic [ltau_pkg::DIV_RW-1:0] den,
  output logic                       done,
  output logic [ltau_pkg::DIV_QB-1:0] quot
);
  import ltau_pkg::*;

  localparam int CW = $clog2(DIV_QB + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_RW-1:0] rem;
  logic [DIV_QB-1:0] low;
  logic [DIV_RW:0]   trial;
  logic              ge;

  // The upper numerator bits are below the divisor for every use.
  assign trial = {rem, low[DIV_QB-1]};
  assign ge    = trial >= {1'b0, den};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DIV_QB);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[DIV_QB +: DIV_RW];
      low  <= num[DIV_QB-1:0];
      quot <= '0;
    end else if (busy && (cnt != '0)) begin
      rem  <= ge ? DIV_RW'(trial - {1'b0, den}) : trial[DIV_RW-1:0];
      low  <= low << 1;
      quot <= {quot[DIV_QB-2:0], ge};
    end
  end

endmodule

// File: design/ltau_rom.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan tables
// Sine table read at two addresses and dB-to-gain table, registered reads.
// ----------------------------------------------------------------------------
module ltau_rom #(
  parameter int SINE_TABLE_DEPTH = ltau_pkg::SINE_DEPTH_DEF,
  parameter int GAIN_TABLE_DEPTH = ltau_pkg::GAIN_DEPTH_DEF,
  parameter int SINE_B = $clog2(SINE_TABLE_DEPTH + 1) - 1,
  parameter int GAIN_AW = $clog2(GAIN_TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic [SINE_B-1:0]  sin_addr,
  input  logic [SINE_B-1:0]  cos_addr,
  input  logic [GAIN_AW-1:0] gain_addr,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q,
  output logic [15:0]        gain_q
);
  import ltau_pkg::*;

  localparam int SINE_E = 1 << SINE_B;
  localparam int STEPS  = (GAIN_TABLE_DEPTH > 1) ? GAIN_TABLE_DEPTH - 1 : 1;

  logic signed [15:0] sin_tab [SINE_E];
  logic [15:0]        gain_tab [GAIN_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_E; k++) begin : g_sin
    localparam logic signed [15:0] V = 16'(sine_entry(k, SINE_B));
    assign sin_tab[k] = V;
  end

  // Entries span -12 dB to +12 dB evenly.
  for (genvar i = 0; i < GAIN_TABLE_DEPTH; i++) begin : g_gain
    localparam longint EN  = longint'(i) * (2 * GAIN_SPAN) - longint'(GAIN_SPAN) * STEPS;
    localparam longint DEN = longint'(5120) * STEPS;
    localparam longint MAG = ((EN < 0) ? -EN : EN) * LOG2_10_Q30;
    localparam longint QQ  = (MAG + DEN / 2) / DEN;
    localparam longint Z   = (EN < 0) ? -QQ : QQ;
    localparam logic [15:0] G = 16'(gain_from_z(Z));
    assign gain_tab[i] = G;
  end

  always_ff @(posedge clk) begin
    sin_q  <= sin_tab[sin_addr];
    cos_q  <= sin_tab[cos_addr];
    gain_q <= gain_tab[gain_addr];
  end

endmodule

// File: design/lfo_tremolo_autopan_unit.sv
// ----------------------------------------------------------------------------
// LFO tremolo and auto-pan unit
// Sine LFO gain modulation and panning of a stereo sample stream.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries one stereo sample pair per
// beat. The output channel (out_valid/out_stall) returns one beat per input
// with both modulated samples and the current gain offset (dB, Q8) and pan
// position (Q12). The configuration channel (cfg_valid/cfg_ready) writes one
// register per beat; cfg_ready is always high and writes belong in idle time.
// Each pair runs through a sequencer that feeds one shift-add multiplier and
// one restoring divider, one bit per cycle. A pair takes nine multiplications,
// two divisions and the sine and gain table reads; mono skips the right
// channel pass and its two multiplications. The next pair is taken when the
// previous one has reached the output register.
// Reset restores the register defaults and clears the LFO phase. A stalled
// result stays in the output register; a new pair can be processed meanwhile
// and waits at the final step until that register is free.
// ----------------------------------------------------------------------------
module lfo_tremolo_autopan_unit #(
  parameter int SAMPLE_BITS      = ltau_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS       = ltau_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ltau_pkg::SINE_DEPTH_DEF,
  parameter int GAIN_TABLE_DEPTH = ltau_pkg::GAIN_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic signed [12:0]            gain_offset,
  output logic signed [13:0]            pan_offset,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ltau_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);
  import ltau_pkg::*;

  localparam int SINE_B  = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int SINE_E  = 1 << SINE_B;
  localparam int GAIN_AW = $clog2(GAIN_TABLE_DEPTH);
  localparam int STEPS   = (GAIN_TABLE_DEPTH > 1) ? GAIN_TABLE_DEPTH - 1 : 1;

  // Sequencer states: one per arithmetic step, plus idle, table and output states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LUT  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_DG   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M4   = 4'd6;
  localparam logic [3:0] S_MI   = 4'd7;
  localparam logic [3:0] S_DI   = 4'd8;
  localparam logic [3:0] S_GA   = 4'd9;
  localparam logic [3:0] S_GB   = 4'd10;
  localparam logic [3:0] S_M5L  = 4'd11;
  localparam logic [3:0] S_M6L  = 4'd12;
  localparam logic [3:0] S_M5R  = 4'd13;
  localparam logic [3:0] S_M6R  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  // Configuration registers and the LFO phase.
  logic [12:0]           variation_amount;
  logic [6:0]            volume_range;
  logic [12:0]           pan_range;
  logic [31:0]           phase_step;
  logic                  stereo_mode;
  logic [PHASE_BITS-1:0] lfo_phase;

  logic [3:0] state;
  logic       pend;

  logic signed [SAMPLE_BITS-1:0] l_s;
  logic signed [SAMPLE_BITS-1:0] r_s;
  logic signed [15:0]            sn;
  logic signed [15:0]            cs;
  logic [18:0]                   vv;
  logic [24:0]                   pv;
  logic signed [12:0]            gdb;
  logic signed [13:0]            pan;
  logic [GAIN_AW-1:0]            idx;
  logic [15:0]                   gain;
  logic [27:0]                   gl;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] ro;

  logic [12:0] var_c;
  logic [6:0]  vr_c;
  logic [12:0] pr_c;
  logic [SINE_B-1:0] si;
  logic [SINE_B-1:0] ci;
  logic signed [15:0] rom_sin;
  logic signed [15:0] rom_cos;
  logic [15:0]        rom_gain;

  logic [15:0]        sn_mag;
  logic [15:0]        cs_mag;
  logic [SAMPLE_BITS:0] l_ext;
  logic [SAMPLE_BITS:0] r_ext;
  logic [SAMPLE_BITS:0] l_mag;
  logic [SAMPLE_BITS:0] r_mag;
  logic [12:0]        lf;
  logic [12:0]        rf;
  logic [12:0]        gdb_bias;
  logic [12:0]        gdb_mag;
  logic [63:0]        pan_sum;
  logic [12:0]        pan_mag;

  logic              mul_state;
  logic              div_state;
  logic              mul_start;
  logic              div_start;
  logic              mul_done;
  logic              div_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_AW-1:0] mul_res;
  logic [MUL_AW-1:0] div_num;
  logic [DIV_RW-1:0] div_den;
  logic [DIV_QB-1:0] div_q;

  logic in_acc;
  logic out_free;

  // Rounds a Q26 product magnitude and saturates the signed result.
  function automatic logic [SAMPLE_BITS-1:0] sat_round(logic [63:0] m, logic neg);
    logic [63:0] q;
    logic [63:0] maxp;
    logic [SAMPLE_BITS-1:0] r;
    q = (m + (64'd1 << 25)) >> 26;
    maxp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    if (!neg) begin
      r = (q > maxp) ? maxp[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
    end else begin
      r = (q > maxp + 64'd1) ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}} : -q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Registers above their legal range act as the range limit.
  assign var_c = (variation_amount > 13'(VAR_MAX)) ? 13'(VAR_MAX) : variation_amount;
  assign vr_c  = (volume_range > 7'(VR_MAX)) ? 7'(VR_MAX) : volume_range;
  assign pr_c  = (pan_range > 13'(PR_MAX)) ? 13'(PR_MAX) : pan_range;

  // The cosine reads the sine table a quarter period ahead.
  assign si = lfo_phase[PHASE_BITS-1 -: SINE_B];
  assign ci = si + SINE_B'(SINE_E / 4);

  assign sn_mag = sn[15] ? 16'(-sn) : 16'(sn);
  assign cs_mag = cs[15] ? 16'(-cs) : 16'(cs);
  assign l_ext  = {l_s[SAMPLE_BITS-1], l_s};
  assign r_ext  = {r_s[SAMPLE_BITS-1], r_s};
  assign l_mag  = l_s[SAMPLE_BITS-1] ? -l_ext : l_ext;
  assign r_mag  = r_s[SAMPLE_BITS-1] ? -r_ext : r_ext;

  // Positive pan pulls left down, negative pan pulls right down; mono applies no pan.
  assign lf = (stereo_mode && !pan[13] && (pan != '0)) ? 13'(UNITY_Q12 - pan) :
              13'(UNITY_Q12);
  assign rf = pan[13] ? 13'(UNITY_Q12 + pan) : 13'(UNITY_Q12);

  assign gdb_bias = 13'(gdb) + 13'(GAIN_SPAN);
  assign gdb_mag  = (div_q > 13'(GAIN_SPAN)) ? 13'(GAIN_SPAN) : div_q;
  assign pan_sum  = mul_res + (64'd1 << 26);
  assign pan_mag  = pan_sum[27 +: 13];

  always_comb begin
    mul_state = 1'b0;
    div_state = 1'b0;
    case (state)
      S_M1, S_M2, S_M3, S_M4, S_MI, S_M5L, S_M6L, S_M5R, S_M6R: mul_state = 1'b1;
      S_DG, S_DI: div_state = 1'b1;
      default: ;
    endcase
  end

  assign mul_start = mul_state && !pend;
  assign div_start = div_state && !pend;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = MUL_AW'(var_c);
        mul_b = MUL_BW'(vr_c);
      end
      S_M2: begin
        mul_a = MUL_AW'(vv);
        mul_b = MUL_BW'(sn_mag);
      end
      S_M3: begin
        mul_a = MUL_AW'(var_c);
        mul_b = MUL_BW'(pr_c);
      end
      S_M4: begin
        mul_a = MUL_AW'(pv);
        mul_b = MUL_BW'(cs_mag);
      end
      S_MI: begin
        mul_a = MUL_AW'(STEPS);
        mul_b = MUL_BW'(gdb_bias);
      end
      S_M5L: begin
        mul_a = MUL_AW'(gain);
        mul_b = MUL_BW'(lf);
      end
      S_M6L: begin
        mul_a = MUL_AW'(gl);
        mul_b = MUL_BW'(l_mag);
      end
      S_M5R: begin
        mul_a = MUL_AW'(gain);
        mul_b = MUL_BW'(rf);
      end
      S_M6R: begin
        mul_a = MUL_AW'(gl);
        mul_b = MUL_BW'(r_mag);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_DI) begin
      div_num = mul_res + MUL_AW'(GAIN_SPAN);
      div_den = DIV_RW'(IDX_DEN);
    end else begin
      div_num = mul_res + MUL_AW'(GDB_DEN / 2);
      div_den = DIV_RW'(GDB_DEN);
    end
  end

  ltau_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  ltau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  ltau_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH),
    .SINE_B           (SINE_B),
    .GAIN_AW          (GAIN_AW)
  ) u_rom (
    .clk       (clk),
    .sin_addr  (si),
    .cos_addr  (ci),
    .gain_addr (idx),
    .sin_q     (rom_sin),
    .cos_q     (rom_cos),
    .gain_q    (rom_gain)
  );

  // Configuration writes and the phase accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      variation_amount <= 13'd901;
      volume_range     <= 7'd12;
      pan_range        <= 13'd492;
      phase_step       <= 32'd357914;
      stereo_mode      <= 1'b1;
      lfo_phase        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VAR:    variation_amount <= cfg_data[12:0];
          CFG_VRANGE: volume_range     <= cfg_data[6:0];
          CFG_PRANGE: pan_range        <= cfg_data[12:0];
          CFG_STEP:   phase_step       <= cfg_data;
          CFG_MODE:   stereo_mode      <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) lfo_phase <= lfo_phase + phase_step[PHASE_BITS-1:0];
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_start || div_start) begin
        pend <= 1'b1;
      end else if (mul_done || div_done) begin
        pend <= 1'b0;
      end
      // A new result may replace the one taken in the same cycle.
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_acc) state <= S_LUT;
        S_LUT:  state <= S_M1;
        S_M1:   if (mul_done) state <= S_M2;
        S_M2:   if (mul_done) state <= S_DG;
        S_DG:   if (div_done) state <= S_M3;
        S_M3:   if (mul_done) state <= S_M4;
        S_M4:   if (mul_done) state <= S_MI;
        S_MI:   if (mul_done) state <= S_DI;
        S_DI:   if (div_done) state <= S_GA;
        S_GA:   state <= S_GB;
        S_GB:   state <= S_M5L;
        S_M5L:  if (mul_done) state <= S_M6L;
        S_M6L:  if (mul_done) state <= stereo_mode ? S_M5R : S_OUT;
        S_M5R:  if (mul_done) state <= S_M6R;
        S_M6R:  if (mul_done) state <= S_OUT;
        S_OUT:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath captures.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_s <= left_in;
      r_s <= right_in;
    end
    case (state)
      S_LUT: begin
        sn <= rom_sin;
        cs <= rom_cos;
      end
      S_M1: if (mul_done) vv <= mul_res[18:0];
      S_DG: if (div_done) gdb <= sn[15] ? -$signed(gdb_mag) : $signed(gdb_mag);
      S_M3: if (mul_done) pv <= mul_res[24:0];
      S_M4: if (mul_done) pan <= cs[15] ? -$signed({1'b0, pan_mag}) : $signed({1'b0, pan_mag});
      S_DI: begin
        if (div_done) begin
          idx <= (div_q > 13'(GAIN_TABLE_DEPTH - 1)) ? GAIN_AW'(GAIN_TABLE_DEPTH - 1) :
                 GAIN_AW'(div_q);
        end
      end
      S_GB: gain <= rom_gain;
      S_M5L, S_M5R: if (mul_done) gl <= mul_res[27:0];
      S_M6L: begin
        if (mul_done) begin
          lo <= sat_round(mul_res, l_s[SAMPLE_BITS-1]);
          if (!stereo_mode) ro <= sat_round(mul_res, l_s[SAMPLE_BITS-1]);
        end
      end
      S_M6R: if (mul_done) ro <= sat_round(mul_res, r_s[SAMPLE_BITS-1]);
      S_OUT: begin
        if (out_free) begin
          left_out    <= lo;
          right_out   <= ro;
          gain_offset <= gdb;
          pan_offset  <= pan;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/ltau_checker.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan port checker
// Temporal checks on the top-level handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfo_tremolo_autopan_unit_assert.svh"

module ltau_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_valid,
  input logic cfg_ready
);

  `LTAU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not held off while a pair is in work")
  `LTAU_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result appeared right after accept")
  `LTAU_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready, "configuration write refused")
  `LTAU_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind lfo_tremolo_autopan_unit ltau_checker u_ltau_checker (.*);

// File: verif/tb_lfo_tremolo_autopan_unit.sv
// ----------------------------------------------------------------------------
// LFO tremolo/auto-pan unit testbench
// Drives stereo sample pairs under random idling, backpressure and register
// settings, predicts every result from an independent fixed-point model of
// the sine LFO, gain table and pan law, and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_lfo_tremolo_autopan_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ltau_pkg::*;

  localparam int SB = 24;
  localparam int SINE_N = 1024;
  localparam int SINE_B = 10;
  localparam int GAIN_N = 256;
  localparam int GAIN_STEPS = GAIN_N - 1;
  localparam longint Q30 = longint'(1) <<< 30;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint LOG2_TEN = 64'sd3566893132;
  localparam longint LN_TWO = 64'sd744261118;
  localparam logic [CFG_IW-1:0] CFG_LAST_INDEX = 3'd7;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic signed [SB-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] SMIN = 24'sh800000;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic signed [12:0]   gain_db;
    logic signed [13:0]   pan;
  } mod_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [SB-1:0] left_in, right_in, left_out, right_out;
  logic signed [12:0] gain_offset;
  logic signed [13:0] pan_offset;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0] cfg_data;

  lfo_tremolo_autopan_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_out(left_out), .right_out(right_out),
    .gain_offset(gain_offset), .pan_offset(pan_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the sine and gain tables and of the block's registers.
  longint sine_tab[SINE_N];
  longint gain_tab[GAIN_N];
  logic [12:0] depth_reg;
  logic [6:0]  vrange_reg;
  logic [12:0] prange_reg;
  logic [31:0] step_reg;
  logic        stereo_reg;
  logic [31:0] lfo_phase;

  mod_beat_t pending_beats[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  int hold_request = 0;
  int hold_left = 0;

  // Rounding division with ties away from zero; den is always positive.
  function automatic longint div_round(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > longint'(SMAX)) return longint'(SMAX);
    if (v < longint'(SMIN)) return longint'(SMIN);
    return v;
  endfunction

  // Fills both tables: sine by a truncated Taylor series over the first
  // quarter folded by symmetry, gain as 2^(dB*log2(10)/20) split into an
  // integer shift and an exponential series on the fractional part.
  task automatic build_tables();
    longint quarter, fold, arg, sq, acc, s, en, z, u, frac, y, term, sum, g;
    int shamt, ipart, k, n, quad;
    quarter = SINE_N / 4;
    for (k = 0; k < SINE_N; k++) begin
      quad = (k / quarter) % 4;
      case (quad)
        0: fold = k;
        1: fold = 2 * quarter - k;
        2: fold = k - 2 * quarter;
        default: fold = 4 * quarter - k;
      endcase
      arg = (fold * HALF_PI + quarter / 2) / quarter;
      sq = (arg * arg) >>> 30;
      acc = Q30;
      acc = Q30 - ((sq * acc) >>> 30) / 110;
      acc = Q30 - ((sq * acc) >>> 30) / 72;
      acc = Q30 - ((sq * acc) >>> 30) / 42;
      acc = Q30 - ((sq * acc) >>> 30) / 20;
      acc = Q30 - ((sq * acc) >>> 30) / 6;
      s = (((arg * acc) >>> 30) + 16384) >>> 15;
      if (s > 32767) s = 32767;
      sine_tab[k] = (quad >= 2) ? -s : s;
    end
    for (k = 0; k < GAIN_N; k++) begin
      en = longint'(k) * (2 * GAIN_SPAN) - longint'(GAIN_SPAN) * GAIN_STEPS;
      z = div_round(en * LOG2_TEN, longint'(5120) * GAIN_STEPS);
      u = z + 2 * Q30;
      ipart = int'(u >>> 30) - 2;
      frac = u & (Q30 - 1);
      y = (frac * LN_TWO) >>> 30;
      sum = Q30;
      term = Q30;
      for (n = 1; n <= 13; n++) begin
        term = ((term * y) >>> 30) / n;
        sum += term;
      end
      shamt = 16 - ipart;
      if (shamt < 1) shamt = 1;
      if (shamt > 40) shamt = 40;
      g = (sum + (longint'(1) <<< (shamt - 1))) >>> shamt;
      if (g > 65535) g = 65535;
      gain_tab[k] = g;
    end
  endtask

  function automatic void restore_defaults();
    depth_reg = 13'd901;
    vrange_reg = 7'd12;
    prange_reg = 13'd492;
    step_reg = 32'd357914;
    stereo_reg = 1'b1;
    lfo_phase = '0;
  endfunction

  // Works out the output beat for one pair and advances the LFO phase.
  function automatic mod_beat_t modulate_pair(logic signed [SB-1:0] l, r);
    mod_beat_t b;
    longint depth, vr, pr, sn, cs, gdb, pan, idx, gain, lf, rf, lo, ro;
    logic [SINE_B-1:0] si, ci;
    depth = (depth_reg > VAR_MAX) ? VAR_MAX : depth_reg;
    vr = (vrange_reg > VR_MAX) ? VR_MAX : vrange_reg;
    pr = (prange_reg > PR_MAX) ? PR_MAX : prange_reg;
    si = lfo_phase[31 -: SINE_B];
    ci = si + SINE_B'(SINE_N / 4);
    sn = sine_tab[si];
    cs = sine_tab[ci];
    gdb = div_round(sn * vr * depth, longint'(10) <<< 19);
    pan = div_round(cs * pr * depth, longint'(1) <<< 27);
    if (gdb > GAIN_SPAN) gdb = GAIN_SPAN;
    if (gdb < -GAIN_SPAN) gdb = -GAIN_SPAN;
    idx = ((gdb + GAIN_SPAN) * GAIN_STEPS + GAIN_SPAN) / (2 * GAIN_SPAN);
    if (idx > GAIN_N - 1) idx = GAIN_N - 1;
    gain = gain_tab[idx];
    lf = UNITY_Q12;
    rf = UNITY_Q12;
    if (stereo_reg) begin
      if (pan > 0) lf = UNITY_Q12 - pan;
      if (pan < 0) rf = UNITY_Q12 + pan;
      lo = clip_sample(div_round(longint'(l) * gain * lf, longint'(1) <<< 26));
      ro = clip_sample(div_round(longint'(r) * gain * rf, longint'(1) <<< 26));
    end else begin
      lo = clip_sample(div_round(longint'(l) * gain * UNITY_Q12, longint'(1) <<< 26));
      ro = lo;
    end
    b.left = lo[SB-1:0];
    b.right = ro[SB-1:0];
    b.gain_db = gdb[12:0];
    b.pan = pan[13:0];
    lfo_phase = lfo_phase + step_reg;
    return b;
  endfunction

  // Offers one pair and waits for the beat to be taken. Valid stays high
  // into the next call unless a random gap drops it first.
  task automatic send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
    mod_beat_t beat;
    if (sender_gaps && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    beat = modulate_pair(l, r);
    pending_beats = {pending_beats, beat};
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    park_input();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_VAR:    depth_reg = val[12:0];
      CFG_VRANGE: vrange_reg = val[6:0];
      CFG_PRANGE: prange_reg = val[12:0];
      CFG_STEP:   step_reg = val;
      CFG_MODE:   stereo_reg = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] depth, vr, pr, step, mode);
    write_reg(CFG_VAR, depth);
    write_reg(CFG_VRANGE, vr);
    write_reg(CFG_PRANGE, pr);
    write_reg(CFG_STEP, step);
    write_reg(CFG_MODE, mode);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2: return w[SB-1:0] & 24'h0000FF;
      default: return w[SB-1:0];
    endcase
  endfunction

  // Extreme samples at the reset settings, then at clamped maximum depth
  // with a quarter-period step so every sine peak and zero is visited, then in mono.
  task automatic test_directed_extremes();
    send_pair(SMAX, SMAX);
    send_pair(SMIN, SMIN);
    send_pair('0, '0);
    send_pair(SMAX, SMIN);
    send_pair(-24'sd1, 24'sd1);
    drain();
    set_all(32'hFFFF_FFFF, 32'h7F, 32'h1FFF, 32'h4000_0000, 32'd1);
    repeat (2) begin
      send_pair(SMAX, SMIN);
      send_pair(SMIN, SMAX);
      send_pair(SMAX, SMAX);
      send_pair(SMIN, SMIN);
    end
    drain();
    write_reg(CFG_MODE, 32'd0);
    repeat (4) send_pair(SMAX, SMIN);
    send_pair(SMIN, SMAX);
    drain();
  endtask

  // Writes to indexes beyond the register list must change nothing.
  task automatic test_unknown_index();
    logic [CFG_IW-1:0] idx;
    set_all(32'd4096, 32'd120, 32'd4096, 32'h1000_0000, 32'd1);
    for (idx = CFG_MODE + 3'd1; idx <= CFG_LAST_INDEX && idx != '0; idx++)
      write_reg(idx, $urandom);
    repeat (4) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  // A step of all ones walks the phase backward and wraps every pair;
  // zero depth and zero ranges hold the gain and pan offsets at zero.
  task automatic test_phase_wrap_and_zero_depth();
    set_all(32'd2048, 32'd60, 32'd2048, 32'hFFFF_FFFF, 32'd1);
    repeat (3) send_pair(rand_sample(), rand_sample());
    drain();
    set_all(32'd0, 32'd0, 32'd0, 32'h0, 32'd1);
    send_pair(SMAX, SMIN);
    send_pair(SMIN, SMAX);
    drain();
  endtask

  // Random settings per phase, extremes among them; one phase runs with
  // no idling on either side.
  task automatic test_random_settings();
    int ph, k;
    logic [31:0] depth, vr, pr, step;
    for (ph = 0; ph < 12; ph++) begin
      depth = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 8191 : 0)
                                          : $urandom_range(0, 8191);
      vr = ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(0, 127);
      pr = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(0, 8191);
      step = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << 26);
      set_all(depth, vr, pr, step, (ph % 3 == 2) ? 0 : 1);
      sender_gaps = (ph != 5);
      receiver_gaps = (ph != 5);
      for (k = 0; k < 150; k++) send_pair(rand_sample(), rand_sample());
      drain();
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // The receiver holds off for a long stretch while pairs keep coming,
  // then the sender pauses for a full drain before going on.
  task automatic test_backpressure_and_pause();
    int k;
    set_all($urandom_range(0, 4096), $urandom_range(0, 120), $urandom_range(0, 4096),
            $urandom, 32'd1);
    sender_gaps = 1'b0;
    hold_request = 3000;
    for (k = 0; k < 30; k++) send_pair(rand_sample(), rand_sample());
    sender_gaps = 1'b1;
    drain();
    for (k = 0; k < 20; k++) send_pair(rand_sample(), rand_sample());
    drain();
    for (k = 0; k < 20; k++) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  // Output side: stall control and comparison against the oldest prediction.
  always @(posedge clk) begin
    mod_beat_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          $error("output beat with no prediction waiting");
          fail_count++;
        end else begin
          e = pending_beats.pop_front();
          if (left_out !== e.left) begin
            $error("left_out expected %0d got %0d", e.left, left_out);
            fail_count++;
          end
          if (right_out !== e.right) begin
            $error("right_out expected %0d got %0d", e.right, right_out);
            fail_count++;
          end
          if (gain_offset !== e.gain_db) begin
            $error("gain_offset expected %0d got %0d", e.gain_db, gain_offset);
            fail_count++;
          end
          if (pan_offset !== e.pan) begin
            $error("pan_offset expected %0d got %0d", e.pan, pan_offset);
            fail_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_gaps && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    left_in = '0;
    right_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    build_tables();
    restore_defaults();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_unknown_index();
    test_phase_wrap_and_zero_depth();
    test_random_settings();
    test_backpressure_and_pause();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
